FILE: rtl/core/pit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_pkg
// Shared widths and types for the point-in-tetrahedron test pipeline.
// ----------------------------------------------------------------------------
package pit_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 4;
  localparam int NUM_VTX     = 4;
  localparam int NUM_AXES    = 3;
  localparam int VTX_WIDTH   = NUM_AXES * COORD_WIDTH;
  localparam int CFG_IDX_W   = 3;

  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int MINOR_W = PROD_W + 1;
  localparam int TRIP_W  = DIFF_W + MINOR_W;
  localparam int SUM_W   = TRIP_W + 2;

  // stages inside one orientation lane
  localparam int NUM_STG = 5;
  // four substituted lanes plus the reference lane
  localparam int NUM_LANES = NUM_VTX + 1;
  localparam int REF_LANE  = NUM_VTX;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_3 = CFG_IDX_W'(3);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [MINOR_W-1:0]     minor_t;
  typedef logic signed [TRIP_W-1:0]      trip_t;
  typedef logic signed [SUM_W-1:0]       sum_t;

  typedef struct packed {
    logic nz;
    logic neg;
  } pit_sign_t;

  typedef struct packed {
    logic [NUM_STG-1:0] en;
  } pit_adv_t;

endpackage

FILE: rtl/core/pit_orient.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_orient
// Five-stage orientation lane: sign of the triple product of the row
// differences of four points (difference, minor products, minors, triple
// products, sum and sign).
// ----------------------------------------------------------------------------
module pit_orient (
  input  logic               clk,
  input  pit_pkg::pit_adv_t  adv,
  input  pit_pkg::coord_t    pts [pit_pkg::NUM_VTX][pit_pkg::NUM_AXES],
  output pit_pkg::pit_sign_t sgn
);

  pit_pkg::diff_t     d_r    [3][pit_pkg::NUM_AXES];
  pit_pkg::diff_t     d0a_r  [pit_pkg::NUM_AXES];
  pit_pkg::diff_t     d0b_r  [pit_pkg::NUM_AXES];
  pit_pkg::prod_t     p_r    [6];
  pit_pkg::minor_t    m_r    [3];
  pit_pkg::trip_t     t_r    [3];
  pit_pkg::sum_t      sum_nxt;
  pit_pkg::pit_sign_t sgn_r;

  always_ff @(posedge clk) begin
    if (adv.en[0]) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < pit_pkg::NUM_AXES; k++) begin
          d_r[i][k] <= pit_pkg::diff_t'(pts[i+1][k]) - pit_pkg::diff_t'(pts[0][k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.en[1]) begin
      p_r[0] <= pit_pkg::prod_t'(d_r[1][1]) * pit_pkg::prod_t'(d_r[2][2]);
      p_r[1] <= pit_pkg::prod_t'(d_r[1][2]) * pit_pkg::prod_t'(d_r[2][1]);
      p_r[2] <= pit_pkg::prod_t'(d_r[1][0]) * pit_pkg::prod_t'(d_r[2][2]);
      p_r[3] <= pit_pkg::prod_t'(d_r[1][2]) * pit_pkg::prod_t'(d_r[2][0]);
      p_r[4] <= pit_pkg::prod_t'(d_r[1][0]) * pit_pkg::prod_t'(d_r[2][1]);
      p_r[5] <= pit_pkg::prod_t'(d_r[1][1]) * pit_pkg::prod_t'(d_r[2][0]);
      d0a_r  <= d_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.en[2]) begin
      m_r[0] <= pit_pkg::minor_t'(p_r[0]) - pit_pkg::minor_t'(p_r[1]);
      m_r[1] <= pit_pkg::minor_t'(p_r[2]) - pit_pkg::minor_t'(p_r[3]);
      m_r[2] <= pit_pkg::minor_t'(p_r[4]) - pit_pkg::minor_t'(p_r[5]);
      d0b_r  <= d0a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.en[3]) begin
      for (int k = 0; k < 3; k++) begin
        t_r[k] <= pit_pkg::trip_t'(d0b_r[k]) * pit_pkg::trip_t'(m_r[k]);
      end
    end
  end

  assign sum_nxt = pit_pkg::sum_t'(t_r[0]) - pit_pkg::sum_t'(t_r[1])
                 + pit_pkg::sum_t'(t_r[2]);

  always_ff @(posedge clk) begin
    if (adv.en[4]) begin
      sgn_r.nz  <= |sum_nxt;
      sgn_r.neg <= sum_nxt[pit_pkg::SUM_W-1];
    end
  end

  assign sgn = sgn_r;

endmodule

FILE: rtl/core/point_in_tetrahedron_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_tetrahedron_test
// Streams points against one tetrahedron held in configuration and flags
// each point as inside (boundary included) or outside.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*  : write the four vertices (index 0..3, data packed z,y,x with x in
//            the low bits) while the pipeline is empty. cfg_ready is always
//            high; indexes above 3 are dropped.
//   in_*   : one point per transfer (in_valid high, in_stall low).
//   out_*  : one inside flag per point, in order; receiver holds out_stall
//            to stall a result.
// Throughput: one point per cycle while the output is not stalled, set by the
//   six-register pipeline of five parallel orientation lanes (four substituted, one reference).
// Stalls: each stage advances when empty or when the next stage advances;
//   in_stall rises only when every stage holds an item and the output is
//   stalled. Nothing is dropped or repeated.
// Reset: clears all valid bits and zeroes the four vertices.
// ----------------------------------------------------------------------------
module point_in_tetrahedron_test (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pit_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pit_pkg::VTX_WIDTH-1:0]       cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [pit_pkg::COORD_WIDTH-1:0] in_pt_z,
  input  logic signed [pit_pkg::COORD_WIDTH-1:0] in_pt_y,
  input  logic signed [pit_pkg::COORD_WIDTH-1:0] in_pt_x,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_inside_res
);

  localparam int CW = pit_pkg::COORD_WIDTH;
  localparam int NS = pit_pkg::NUM_STG;

  logic [pit_pkg::VTX_WIDTH-1:0] vtx_r [pit_pkg::NUM_VTX];
  pit_pkg::coord_t               verts [pit_pkg::NUM_VTX][pit_pkg::NUM_AXES];
  pit_pkg::coord_t               pt    [pit_pkg::NUM_AXES];
  pit_pkg::coord_t               lane_pts [pit_pkg::NUM_LANES][pit_pkg::NUM_VTX][pit_pkg::NUM_AXES];
  pit_pkg::pit_sign_t            lane_sgn [pit_pkg::NUM_LANES];

  logic [NS-1:0] v_r;
  logic [NS:0]   vin;
  logic [NS:0]   rdy;
  logic [NS:0]   en;
  pit_pkg::pit_adv_t adv;
  logic          out_valid_r;
  logic          inside_r;
  logic          inside_nxt;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pit_pkg::NUM_VTX; i++) begin
        vtx_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready
                 && (cfg_index inside {[pit_pkg::REG_VERTEX_0 : pit_pkg::REG_VERTEX_3]})) begin
      vtx_r[cfg_index[1:0]] <= cfg_wdata;
    end
  end

  always_comb begin
    for (int i = 0; i < pit_pkg::NUM_VTX; i++) begin
      verts[i][0] = vtx_r[i][3*CW-1:2*CW];
      verts[i][1] = vtx_r[i][2*CW-1:CW];
      verts[i][2] = vtx_r[i][CW-1:0];
    end
    pt[0] = in_pt_z;
    pt[1] = in_pt_y;
    pt[2] = in_pt_x;
    for (int l = 0; l < pit_pkg::NUM_LANES; l++) begin
      for (int i = 0; i < pit_pkg::NUM_VTX; i++) begin
        for (int k = 0; k < pit_pkg::NUM_AXES; k++) begin
          lane_pts[l][i][k] = (l == i) ? pt[k] : verts[i][k];
        end
      end
    end
  end

  // pipeline control
  always_comb begin
    vin[0] = in_valid;
    for (int k = 1; k <= NS; k++) begin
      vin[k] = v_r[k-1];
    end
    rdy[NS] = !out_valid_r || !out_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    en = rdy & vin;
  end

  assign adv.en   = en[NS-1:0];
  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= vin[k];
        end
      end
      if (rdy[NS]) begin
        out_valid_r <= vin[NS];
      end
    end
  end

  for (genvar l = 0; l < pit_pkg::NUM_LANES; l++) begin : g_lane
    pit_orient u_orient (
      .clk (clk),
      .adv (adv),
      .pts (lane_pts[l]),
      .sgn (lane_sgn[l])
    );
  end

  always_comb begin
    inside_nxt = 1'b1;
    for (int l = 0; l < pit_pkg::NUM_VTX; l++) begin
      if (lane_sgn[l].nz && (lane_sgn[l] != lane_sgn[pit_pkg::REF_LANE])) begin
        inside_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS]) begin
      inside_r <= inside_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = inside_r;

endmodule

FILE: rtl/core/pit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_checker
// Port-level checks for the point-in-tetrahedron test.
// ----------------------------------------------------------------------------
module pit_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_inside_res
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_inside_res))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output empty");

  a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

endmodule

bind point_in_tetrahedron_test pit_checker u_pit_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_inside_res (out_inside_res)
);
